// File: design/kt_pkg.sv
// Package: token kinds, lexer modes, keyword table and helper functions.
package kt_pkg;

    localparam int NUM_KW = 26;
    localparam int KW_SLOTS = 17;

    typedef enum logic [5:0] {
        TK_EOF    = 6'd0,
        TK_IDENT  = 6'd1,
        TK_NUMBER = 6'd2,
        TK_STRING = 6'd3,
        TK_ARROW  = 6'd4,
        TK_AND    = 6'd5,
        TK_OR     = 6'd6,
        TK_EQ     = 6'd7,
        TK_NE     = 6'd8,
        TK_LE     = 6'd9,
        TK_GE     = 6'd10,
        TK_LT     = 6'd11,
        TK_GT     = 6'd12,
        TK_CHAR   = 6'd13,
        TK_KW0    = 6'd14
    } token_kind_t;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_IDENT   = 6'b000100,
        MODE_NUMBER  = 6'b001000,
        MODE_STRING  = 6'b010000,
        MODE_OPER    = 6'b100000
    } lex_mode_t;

    // Front-to-back item: a source byte with its end-of-input mark.
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } lex_item_t;

    // Keyword character at a position; 0 past the end.
    function automatic logic [7:0] kw_char(input int unsigned kw, input int unsigned pos);
        string s;
        s = "";
        unique case (kw)
            0: s = "state";   1: s = "event";   2: s = "emit";   3: s = "from";
            4: s = "on";      5: s = "after";   6: s = "when";   7: s = "do";
            8: s = {"start", "_timer"}; 9: s = {"cancel", "_timer"};
            10: s = "set"; 11: s = "map";
            12: s = "entry";  13: s = "exit";   14: s = "guard"; 15: s = "action";
            16: s = "machine"; 17: s = "initial"; 18: s = "bool"; 19: s = "int";
            20: s = "double"; 21: s = "true";   22: s = "false"; 23: s = "else";
            24: s = "while";  25: s = "if";
            default: s = "";
        endcase
        if (pos < s.len())
            return s[pos];
        return 8'd0;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "-" || c == "&" || c == "|" || c == "=" || c == "!" ||
               c == "<" || c == ">";
    endfunction

endpackage

// File: design/keyword_tokenizer_unit.sv
// Top level of the keyword tokenizer.
//
// Input channel: in_valid/in_ready carry one source byte (in_byte) or an
// end-of-input mark (end_of_input) per transfer.
// Output channel: out_valid/out_ready carry one token per transfer; last
// marks the final token caused by one input byte.
// A byte passes a two-entry input queue, then the lexer stage, which
// writes its tokens into a two-entry output buffer.
// Throughput is one byte per cycle while the receiver takes every token;
// a byte that yields two tokens holds the lexer while the output buffer
// drains.
// Reset clears both queues and puts the lexer in idle.
// When the receiver stalls the output buffer fills, the lexer stops, and
// the input queue fills before in_ready drops.
module keyword_tokenizer_unit
    import kt_pkg::*;
#(
    parameter int MANTISSA_BITS   = 32,
    parameter int LENGTH_BITS     = 8,
    parameter int KEYWORD_MAX_LEN = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [7:0]  char_code,
    output logic [7:0]  lexeme_length,
    output logic [31:0] mantissa,
    output logic [7:0]  fraction_digits,
    output logic        unterminated,
    output logic        overflow,
    output logic        last
);

    lex_item_t q_item;
    logic      q_valid, q_pop;

    kt_front u_front (
        .clk, .rst_n, .in_byte, .end_of_input, .in_valid, .in_ready,
        .q_item, .q_valid, .q_pop
    );

    kt_back #(
        .MANTISSA_BITS(MANTISSA_BITS), .LENGTH_BITS(LENGTH_BITS),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_back (
        .clk, .rst_n, .q_item, .q_valid, .q_pop, .out_valid, .out_ready,
        .token_kind, .char_code, .lexeme_length, .mantissa, .fraction_digits,
        .unterminated, .overflow, .last
    );

endmodule

// File: design/kt_front.sv
// Front end: accepts source bytes into a small queue.
module kt_front
    import kt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    input  logic       in_valid,
    output logic       in_ready,
    output lex_item_t  q_item,
    output logic       q_valid,
    input  logic       q_pop
);

    lex_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= '{ch: in_byte, eoi: end_of_input};
    end

endmodule

// File: design/kt_back.sv
// Back end: lexer state machine and two-entry output buffer.
module kt_back
    import kt_pkg::*;
#(
    parameter int MANTISSA_BITS   = 32,
    parameter int LENGTH_BITS     = 8,
    parameter int KEYWORD_MAX_LEN = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lex_item_t   q_item,
    input  logic        q_valid,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [7:0]  char_code,
    output logic [7:0]  lexeme_length,
    output logic [31:0] mantissa,
    output logic [7:0]  fraction_digits,
    output logic        unterminated,
    output logic        overflow,
    output logic        last
);

    localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = '1;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;
    localparam logic [MANTISSA_BITS-1:0] MANT_LIM = MANT_MAX / 10;
    localparam logic [3:0]               MANT_REM = 4'(MANT_MAX % 10);

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic [7:0]  len;
        logic [31:0] mant;
        logic [7:0]  frac;
        logic        unterm;
        logic        ovf;
        logic        last;
    } tok_t;

    lex_mode_t               mode_reg, mode_next;
    logic [7:0]              op_reg, op_next;
    logic [NUM_KW-1:0]       cand_reg, cand_next;
    logic [LENGTH_BITS-1:0]  cnt_reg, cnt_next;
    logic [MANTISSA_BITS-1:0] mant_reg, mant_next;
    logic [LENGTH_BITS-1:0]  frac_reg, frac_next;
    logic                    dot_reg, dot_next, sat_reg, sat_next;

    tok_t       buf_reg [2];
    tok_t       buf_next [2];
    logic [1:0] bcnt_reg, bcnt_next;
    logic [1:0] n_tok;
    tok_t       t0, t1;

    // Accept a byte only if both output slots could be filled
    assign q_pop     = q_valid && (bcnt_reg == 2'd0 || (bcnt_reg == 2'd1 && out_ready));
    assign out_valid = (bcnt_reg != 2'd0);
    assign token_kind      = buf_reg[0].kind;
    assign char_code       = buf_reg[0].ch;
    assign lexeme_length   = buf_reg[0].len;
    assign mantissa        = buf_reg[0].mant;
    assign fraction_digits = buf_reg[0].frac;
    assign unterminated    = buf_reg[0].unterm;
    assign overflow        = buf_reg[0].ovf;
    assign last            = buf_reg[0].last;

    function automatic tok_t mk(input logic [5:0] k, input logic [7:0] c,
                                input logic [7:0] l, input logic [31:0] m,
                                input logic [7:0] f, input logic u, input logic o);
        tok_t t;
        t = '{kind: k, ch: c, len: l, mant: m, frac: f, unterm: u, ovf: o, last: 1'b0};
        return t;
    endfunction

    // Lexer step
    always_comb
    begin
        logic [7:0]  c;
        logic [5:0]  kk;
        logic        restart, one_op;
        logic [MANTISSA_BITS+3:0] prod;
        logic [3:0]  d;
        logic [7:0]  lw;
        logic [31:0] mw;
        logic [7:0]  fw;
        c = q_item.ch;
        mode_next = mode_reg; op_next = op_reg; cand_next = cand_reg; cnt_next = cnt_reg;
        mant_next = mant_reg; frac_next = frac_reg; dot_next = dot_reg; sat_next = sat_reg;
        n_tok = 2'd0; t0 = '0; t1 = '0; restart = 1'b0; kk = TK_IDENT; one_op = 1'b0;
        lw = 8'(cnt_reg); mw = 32'(mant_reg); fw = 8'(frac_reg);
        prod = '0; d = '0;

        // Identifier kind from current candidates
        if (!sat_reg && 32'(cnt_reg) <= 16)
        begin
            for (int i = NUM_KW - 1; i >= 0; i--)
            begin
                if (cand_reg[i] && kw_char(i, 32'(cnt_reg)) == 8'd0)
                    kk = 6'(TK_KW0 + i);
            end
        end

        // Close current token
        unique case (mode_reg)
            MODE_IDENT:
                if (q_item.eoi || !is_word(c))
                begin
                    t0 = mk(kk, 8'd0, lw, 32'd0, 8'd0, 1'b0, sat_reg);
                    n_tok = 2'd1; restart = 1'b1;
                end
            MODE_NUMBER:
                if (q_item.eoi || !(is_digit(c) || (c == "." && !dot_reg)))
                begin
                    t0 = mk(TK_NUMBER, 8'd0, 8'd0, mw, fw, 1'b0, sat_reg);
                    n_tok = 2'd1; restart = 1'b1;
                end
            MODE_STRING:
                if (q_item.eoi || c == "\"" || c == 8'd10)
                begin
                    t0 = mk(TK_STRING, 8'd0, lw, 32'd0, 8'd0, c != "\"" || q_item.eoi,
                            sat_reg);
                    n_tok = 2'd1; mode_next = MODE_IDLE;
                end
                else if (cnt_reg != LEN_MAX)
                    cnt_next = cnt_reg + 1'b1;
                else
                    sat_next = 1'b1;
            MODE_OPER:
            begin
                one_op = 1'b1;
                if (!q_item.eoi)
                begin
                    if (op_reg == "-" && c == ">") begin kk = TK_ARROW; one_op = 1'b0; end
                    else if (op_reg == "&" && c == "&") begin kk = TK_AND; one_op = 1'b0; end
                    else if (op_reg == "|" && c == "|") begin kk = TK_OR; one_op = 1'b0; end
                    else if (c == "=" && op_reg == "=") begin kk = TK_EQ; one_op = 1'b0; end
                    else if (c == "=" && op_reg == "!") begin kk = TK_NE; one_op = 1'b0; end
                    else if (c == "=" && op_reg == "<") begin kk = TK_LE; one_op = 1'b0; end
                    else if (c == "=" && op_reg == ">") begin kk = TK_GE; one_op = 1'b0; end
                end
                if (one_op)
                begin
                    if (op_reg == "<")
                        t0 = mk(TK_LT, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
                    else if (op_reg == ">")
                        t0 = mk(TK_GT, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
                    else
                        t0 = mk(TK_CHAR, op_reg, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
                    restart = 1'b1;
                end
                else
                begin
                    t0 = mk(kk, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
                    mode_next = MODE_IDLE;
                end
                n_tok = 2'd1;
            end
            MODE_COMMENT:
                if (q_item.eoi || c == 8'd10 || c == 8'd13)
                    mode_next = MODE_IDLE;
            default:
                restart = 1'b1;
        endcase

        // Continue identifier
        if (mode_reg == MODE_IDENT && !restart)
        begin
            for (int i = 0; i < NUM_KW; i++)
            begin
                if (32'(cnt_reg) >= KEYWORD_MAX_LEN || 32'(cnt_reg) >= 16 ||
                    kw_char(i, 32'(cnt_reg)) != c)
                    cand_next[i] = 1'b0;
            end
            if (cnt_reg != LEN_MAX) cnt_next = cnt_reg + 1'b1;
            else sat_next = 1'b1;
        end

        // Continue number (digit or first dot)
        if (mode_reg == MODE_NUMBER && !restart)
        begin
            if (c == ".")
                dot_next = 1'b1;
            else
            begin
                d = 4'(c - "0");
                if (mant_reg > MANT_LIM || (mant_reg == MANT_LIM && d > MANT_REM))
                begin
                    mant_next = MANT_MAX; sat_next = 1'b1;
                end
                else
                begin
                    prod = ({4'd0, mant_reg} << 3) + ({4'd0, mant_reg} << 1) + (MANTISSA_BITS+4)'(d);
                    mant_next = prod[MANTISSA_BITS-1:0];
                end
                if (dot_reg)
                begin
                    if (frac_reg != LEN_MAX) frac_next = frac_reg + 1'b1;
                    else sat_next = 1'b1;
                end
            end
        end

        // End of input closes with eof; otherwise start from idle with this byte
        if (q_item.eoi)
        begin
            mode_next = MODE_IDLE;
            if (n_tok == 2'd0) t0 = mk(TK_EOF, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
            else t1 = mk(TK_EOF, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
            n_tok = n_tok + 2'd1;
        end
        else if (restart)
        begin
            mode_next = MODE_IDLE;
            if (is_space(c))
                mode_next = MODE_IDLE;
            else if (c == "#")
                mode_next = MODE_COMMENT;
            else if (is_alpha(c) || c == "_")
            begin
                mode_next = MODE_IDENT;
                sat_next = 1'b0;
                cnt_next = LENGTH_BITS'(1);
                for (int i = 0; i < NUM_KW; i++)
                    cand_next[i] = (KEYWORD_MAX_LEN > 0) && kw_char(i, 0) == c;
            end
            else if (is_digit(c) || c == ".")
            begin
                mode_next = MODE_NUMBER;
                sat_next  = 1'b0;
                frac_next = '0;
                dot_next  = (c == ".");
                mant_next = (c == ".") ? '0 : MANTISSA_BITS'(c - "0");
            end
            else if (c == "\"")
            begin
                mode_next = MODE_STRING;
                cnt_next  = '0;
                sat_next  = 1'b0;
            end
            else if (is_op(c))
            begin
                mode_next = MODE_OPER;
                op_next   = c;
            end
            else
            begin
                if (n_tok == 2'd0) t0 = mk(TK_CHAR, c, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
                else t1 = mk(TK_CHAR, c, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0);
                n_tok = n_tok + 2'd1;
            end
        end
        if (n_tok == 2'd1) t0.last = 1'b1;
        if (n_tok == 2'd2) t1.last = 1'b1;
    end

    // Output buffer: slot 0 is the head
    always_comb
    begin
        logic pop;
        logic [1:0] base;
        pop = out_valid && out_ready;
        buf_next[0] = buf_reg[0];
        buf_next[1] = buf_reg[1];
        if (pop) buf_next[0] = buf_reg[1];
        base = bcnt_reg - {1'b0, pop};
        if (q_pop && n_tok != 2'd0)
        begin
            if (base == 2'd0)
            begin
                buf_next[0] = t0;
                buf_next[1] = t1;
            end
            else
                buf_next[1] = t0;
        end
        bcnt_next = base + ((q_pop) ? n_tok : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            op_reg   <= '0;
            cand_reg <= '1;
            cnt_reg  <= '0;
            mant_reg <= '0;
            frac_reg <= '0;
            dot_reg  <= 1'b0;
            sat_reg  <= 1'b0;
            bcnt_reg <= 2'd0;
        end
        else
        begin
            if (q_pop)
            begin
                mode_reg <= mode_next;
                op_reg   <= op_next;
                cand_reg <= cand_next;
                cnt_reg  <= cnt_next;
                mant_reg <= mant_next;
                frac_reg <= frac_next;
                dot_reg  <= dot_next;
                sat_reg  <= sat_next;
            end
            bcnt_reg <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg[0] <= buf_next[0];
        buf_reg[1] <= buf_next[1];
    end

endmodule

// File: design/kt_checker.sv
// Port-level checker for the keyword tokenizer, bound to the top level.
module kt_checker
    import kt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] token_kind,
    input logic       last
);

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == TK_EOF |-> last)
        else $error("eof token without last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("output changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= 6'd39)
        else $error("token kind out of range");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind keyword_tokenizer_unit kt_checker u_kt_checker (
    .clk, .rst_n, .out_valid, .out_ready, .token_kind, .last
);

// File: dv/keyword_tokenizer_checker.sv
// Checker: watches both channels, predicts tokens per byte and compares them.
`timescale 1ns / 100ps
module keyword_tokenizer_checker
    import kt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  token_kind,
    input  logic [7:0]  char_code,
    input  logic [7:0]  lexeme_length,
    input  logic [31:0] mantissa,
    input  logic [7:0]  fraction_digits,
    input  logic        unterminated,
    input  logic        overflow,
    input  logic        last,
    output int          fail_count,
    output int          pending_tokens,
    output int          token_total
);
    typedef enum int {LX_IDLE, LX_COMMENT, LX_IDENT, LX_NUMBER, LX_STRING, LX_OPER} lx_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic [7:0]  len;
        logic [31:0] mant;
        logic [7:0]  frac;
        logic        unterm;
        logic        ovf;
        logic        lst;
    } token_t;

    localparam logic [25:0] ALL_KW = '1;
    localparam int LEN_SAT = 255;
    localparam logic [31:0] MANT_SAT = 32'hFFFF_FFFF;

    token_t token_q[$];
    lx_t         mode;
    logic [7:0]  op_char;
    logic [25:0] cand;
    int          count;
    logic [31:0] mant_acc;
    int          frac_cnt;
    logic        dot_seen;
    logic        sat;
    string       kw_names[26] = '{"state", "event", "emit", "from", "on", "after", "when",
        "do", {"start", "_timer"}, {"cancel", "_timer"}, "set", "map", "entry", "exit",
        "guard", "action", "machine", "initial", "bool", "int", "double", "true", "false",
        "else", "while", "if"};

    assign pending_tokens = token_q.size();

    function automatic bit sp(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit dg(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit al(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic push_tok(int k, int c, int l, logic [31:0] m, int f, bit u, bit o);
        token_t t;
        t = '{kind: k[5:0], ch: c[7:0], len: l[7:0], mant: m, frac: f[7:0],
              unterm: u, ovf: o, lst: 1'b0};
        token_q.push_back(t);
    endtask

    task automatic bump();
        if (count < LEN_SAT) count++;
        else sat = 1;
    endtask

    task automatic ident_add(logic [7:0] c);
        for (int i = 0; i < 26; i++)
            if (count >= 12 || count >= kw_names[i].len() || kw_names[i][count] != c)
                cand[i] = 1'b0;
        bump();
    endtask

    task automatic number_add(logic [7:0] c);
        logic [63:0] d;
        if (c == ".") begin
            dot_seen = 1;
            return;
        end
        d = 64'(c - "0");
        if (64'(mant_acc) > (64'(MANT_SAT) - d) / 10) begin
            mant_acc = MANT_SAT;
            sat = 1;
        end else
            mant_acc = 32'(64'(mant_acc) * 10 + d);
        if (dot_seen) begin
            if (frac_cnt < LEN_SAT) frac_cnt++;
            else sat = 1;
        end
    endtask

    task automatic ident_done();
        int k;
        k = TK_IDENT;
        if (!sat && count <= 16)
            for (int i = 0; i < 26; i++)
                if (cand[i] && kw_names[i].len() == count) begin
                    k = TK_KW0 + i;
                    break;
                end
        push_tok(k, 0, count, 0, 0, 0, sat);
    endtask

    task automatic op_done();
        if (op_char == "<") push_tok(TK_LT, 0, 0, 0, 0, 0, 0);
        else if (op_char == ">") push_tok(TK_GT, 0, 0, 0, 0, 0, 0);
        else push_tok(TK_CHAR, op_char, 0, 0, 0, 0, 0);
    endtask

    task automatic lex_fresh(logic [7:0] c);
        mode = LX_IDLE;
        if (sp(c)) return;
        if (c == "#") mode = LX_COMMENT;
        else if (al(c) || c == "_") begin
            mode = LX_IDENT; cand = ALL_KW; count = 0; sat = 0;
            ident_add(c);
        end else if (dg(c) || c == ".") begin
            mode = LX_NUMBER; mant_acc = 0; frac_cnt = 0; dot_seen = 0; sat = 0;
            number_add(c);
        end else if (c == "\"") begin
            mode = LX_STRING; count = 0; sat = 0;
        end else if (c == "-" || c == "&" || c == "|" || c == "=" || c == "!" ||
                     c == "<" || c == ">") begin
            mode = LX_OPER; op_char = c;
        end else
            push_tok(TK_CHAR, c, 0, 0, 0, 0, 0);
    endtask

    function automatic int pair_of(logic [7:0] a, logic [7:0] b);
        if (a == "-" && b == ">") return TK_ARROW;
        if (a == "&" && b == "&") return TK_AND;
        if (a == "|" && b == "|") return TK_OR;
        if (b == "=") begin
            if (a == "=") return TK_EQ;
            if (a == "!") return TK_NE;
            if (a == "<") return TK_LE;
            if (a == ">") return TK_GE;
        end
        return 0;
    endfunction

    // Predict the tokens of one accepted byte and mark the last one.
    task automatic predict_tokens(logic [7:0] c, logic eoi);
        int before_n;
        int k;
        before_n = token_q.size();
        if (eoi) begin
            case (mode)
                LX_IDENT: ident_done();
                LX_NUMBER: push_tok(TK_NUMBER, 0, 0, mant_acc, frac_cnt, 0, sat);
                LX_STRING: push_tok(TK_STRING, 0, count, 0, 0, 1, sat);
                LX_OPER: op_done();
                default: ;
            endcase
            push_tok(TK_EOF, 0, 0, 0, 0, 0, 0);
            mode = LX_IDLE;
        end else begin
            case (mode)
                LX_COMMENT: if (c == "\n" || c == "\r") mode = LX_IDLE;
                LX_IDENT:
                    if (al(c) || dg(c) || c == "_") ident_add(c);
                    else begin
                        ident_done();
                        lex_fresh(c);
                    end
                LX_NUMBER:
                    if (dg(c) || (c == "." && !dot_seen)) number_add(c);
                    else begin
                        push_tok(TK_NUMBER, 0, 0, mant_acc, frac_cnt, 0, sat);
                        lex_fresh(c);
                    end
                LX_STRING:
                    if (c == "\"" || c == "\n") begin
                        push_tok(TK_STRING, 0, count, 0, 0, c == "\n", sat);
                        mode = LX_IDLE;
                    end else bump();
                LX_OPER: begin
                    k = pair_of(op_char, c);
                    if (k != 0) begin
                        push_tok(k, 0, 0, 0, 0, 0, 0);
                        mode = LX_IDLE;
                    end else begin
                        op_done();
                        lex_fresh(c);
                    end
                end
                default: lex_fresh(c);
            endcase
        end
        if (token_q.size() > before_n) token_q[token_q.size() - 1].lst = 1'b1;
    endtask

    // Sample both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        token_t got;
        token_t want;
        if (!rst_n) begin
            mode = LX_IDLE; op_char = 0; cand = ALL_KW; count = 0;
            mant_acc = 0; frac_cnt = 0; dot_seen = 0; sat = 0;
            fail_count = 0; token_total = 0;
            token_q.delete();
        end else begin
            if (out_valid && out_ready) begin
                token_total++;
                got = '{kind: token_kind, ch: char_code, len: lexeme_length, mant: mantissa,
                        frac: fraction_digits, unterm: unterminated, ovf: overflow, lst: last};
                if (token_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Mismatch: unexpected token kind %0d", token_kind);
                end else begin
                    want = token_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Mismatch: exp k%0d c%0d l%0d m%0d f%0d u%0b o%0b t%0b",
                                     want.kind, want.ch, want.len, want.mant, want.frac,
                                     want.unterm, want.ovf, want.lst);
                            $display("          got k%0d c%0d l%0d m%0d f%0d u%0b o%0b t%0b",
                                     got.kind, got.ch, got.len, got.mant, got.frac,
                                     got.unterm, got.ovf, got.lst);
                        end
                    end
                end
            end
            if (in_valid && in_ready) predict_tokens(in_byte, end_of_input);
        end
    end
endmodule

// File: dv/keyword_tokenizer_unit_tb.sv
// Testbench top: source-text stimulus, receiver stalls and final verdict.
`timescale 1ns / 100ps
module keyword_tokenizer_unit_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'd0;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  token_kind;
    logic [7:0]  char_code;
    logic [7:0]  lexeme_length;
    logic [31:0] mantissa;
    logic [7:0]  fraction_digits;
    logic        unterminated;
    logic        overflow;
    logic        last;
    int          fail_count;
    int          pending_tokens;
    int          token_total;
    int          bytes_sent = 0;
    int          idle_cycles = 0;
    int          rx_gap = 0;
    bit          long_hold = 1'b0;
    bit          hold_done = 1'b0;
    bit          drive_done = 1'b0;

    localparam int WATCHDOG = 20000;

    keyword_tokenizer_unit u_top (.*);

    keyword_tokenizer_checker u_chk (.*);

    always #4 clk = ~clk;

    string kw_list[26] = '{"state", "event", "emit", "from", "on", "after", "when",
        "do", {"start", "_timer"}, {"cancel", "_timer"}, "set", "map", "entry", "exit",
        "guard", "action", "machine", "initial", "bool", "int", "double", "true", "false",
        "else", "while", "if"};
    string op_list[14] = '{"->", "&&", "||", "==", "!=", "<=", ">=", "<", ">", "-", "&",
        "|", "=", "!"};

    function automatic int gap_len();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // One transfer on the input channel; valid stays up until accepted and
    // drops only when a gap follows.
    task automatic send(logic [7:0] b, logic eoi);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        end_of_input <= eoi;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
    endtask

    // Random lexeme: mostly well-formed, with some random bytes and an occasional end-of-input mark.
    task automatic send_lexeme();
        int n;
        case ($urandom_range(0, 9))
            0, 1: send_text(kw_list[$urandom_range(0, 25)]);
            2: begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send(i == 0 ? 8'("a" + $urandom_range(0, 25)) :
                         8'("0" + $urandom_range(0, 9)) | 8'($urandom_range(0, 1) << 6), 0);
            end
            3: begin
                n = $urandom_range(1, 14);
                for (int i = 0; i < n; i++) send(8'("0" + $urandom_range(0, 9)), 0);
                if ($urandom_range(0, 1)) send(".", 0);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) send(8'("0" + $urandom_range(0, 9)), 0);
            end
            4: begin
                send("\"", 0);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) send(8'($urandom_range(32, 126)) & 8'hfd, 0);
                send($urandom_range(0, 4) ? "\"" : "\n", 0);
            end
            5: send_text(op_list[$urandom_range(0, 13)]);
            6: begin
                send("#", 0);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) send(8'($urandom_range(0, 255)) & 8'hf7, 0);
                send($urandom_range(0, 1) ? "\n" : "\r", 0);
            end
            7: send(8'($urandom_range(0, 255)), 0);
            8: send(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            default: send(8'($urandom_range(9, 13)), 0);
        endcase
        if ($urandom_range(0, 2) != 0) send(" ", 0);
    endtask

    // Receiver: random stall runs, one long hold-off while the sender keeps going.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                rx_gap = gap_len();
                if (rx_gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (rx_gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else if (rst_n && !drive_done) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: keywords, operators, numbers, strings and end cases.
        send_text("state x1 ->&&||==!=<=>=<>");
        send_text("12.5.3 . \"ab\" \"cut\n# note\n");
        send(8'hff, 0);
        send(8'h80, 0);
        send_text({"start", "_timer can", "cel_timer if iff _ 4294967296 1."});
        send_text("\"open");
        send(0, 1);
        send("<", 0);
        send(8'h55, 1);
        send("a", 0);
        send(0, 1);
        // Long lexemes saturate length and mantissa.
        for (int i = 0; i < 300; i++) send("z", 0);
        send(" ", 0);
        send("\"", 0);
        for (int i = 0; i < 270; i++) send("q", 0);
        send("\"", 0);
        send(".", 0);
        for (int i = 0; i < 260; i++) send("7", 0);
        send(" ", 0);
        long_hold = 1'b1;
        // Random source text.
        while (bytes_sent < 1600) send_lexeme();
        send(0, 1);
        in_valid <= 1'b0;
        drive_done = 1'b1;
        @(posedge clk);
        fork
            begin
                wait (pending_tokens == 0);
                repeat (20) @(posedge clk);
            end
            begin
                repeat (WATCHDOG) @(posedge clk);
                $display("Regression FAIL");
                $finish;
            end
        join_any
        $display("Covered %0d bytes, %0d tokens: keywords, operators, numbers, strings,",
                 bytes_sent, token_total);
        $display("comments, saturation, end-of-input with open tokens, random stalls.");
        if (fail_count == 0 && pending_tokens == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
